// ===== sv/tte_pkg.sv =====
// Shared types, constants and helpers for the tab expander.
package tte_pkg;

  localparam int MAX_STOPS_DEFAULT   = 28;
  localparam int COLUMN_BITS_DEFAULT = 16;

  localparam int STOP_WORDS     = 4;
  localparam int STOPS_PER_WORD = 7;
  localparam int STOP_BITS      = 9;
  localparam int STOP_WORD_BITS = STOPS_PER_WORD * STOP_BITS;
  localparam int STOP_SLOTS     = STOP_WORDS * STOPS_PER_WORD;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] TAB_CHAR   = 8'd9;
  localparam logic [7:0] BS_CHAR    = 8'd8;
  localparam logic [7:0] NL_CHAR    = 8'd10;
  localparam logic [7:0] SPACE_CHAR = 8'd32;

  localparam logic [STOP_BITS-1:0] MAX_STOP_VALUE = 9'd256;
  localparam logic [3:0]           DEFAULT_WIDTH  = 4'd8;

  // register indexes on the config port
  localparam logic [2:0] REG_STOP_COUNT  = 3'd0;
  localparam logic [2:0] REG_STOP_WORD_0 = 3'd1;
  localparam logic [2:0] REG_STOP_WORD_3 = 3'd4;

  typedef enum logic [1:0] {
    KIND_TEXT,
    KIND_TAB,
    KIND_BS,
    KIND_NL
  } kind_t;

  typedef logic [STOP_WORDS-1:0][STOP_WORD_BITS-1:0] stop_words_t;

  typedef struct packed {
    logic [4:0]  stop_count;
    stop_words_t words;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] text_byte;
    logic       new_file;
  } q_entry_t;

  // stop n, clamped to 256
  function automatic logic [STOP_BITS-1:0] stop_at(input stop_words_t words, input int n);
    int                   w;
    int                   s;
    logic [STOP_BITS-1:0] v;
    w = n / STOPS_PER_WORD;
    s = n % STOPS_PER_WORD;
    v = words[2'(w)][6'(s*STOP_BITS) +: STOP_BITS];
    return (v > MAX_STOP_VALUE) ? MAX_STOP_VALUE : v;
  endfunction

endpackage

// ===== sv/tte_front.sv =====
// Input side: classifies each byte and holds it in a short queue for the back end.
module tte_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] text_byte
  input  logic              s_tuser,   // [0] new_file
  output logic              q_valid,
  output tte_pkg::q_entry_t q_head,
  input  logic              q_pop
);
  import tte_pkg::*;

  q_entry_t               mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QPTR_BITS:0]     count;
  logic                   push;
  q_entry_t               entry;

  always_comb begin
    entry.text_byte = s_tdata;
    entry.new_file  = s_tuser;
    case (s_tdata)
      TAB_CHAR: entry.kind = KIND_TAB;
      BS_CHAR:  entry.kind = KIND_BS;
      NL_CHAR:  entry.kind = KIND_NL;
      default:  entry.kind = KIND_TEXT;
    endcase
  end

  assign s_tready = (count != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_BITS+1)'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// ===== sv/tte_back.sv =====
// Back end: column and phase tracking, tab stop search, registered result beat.
module tte_back #(
  parameter int MAX_STOPS   = tte_pkg::MAX_STOPS_DEFAULT,
  parameter int COLUMN_BITS = tte_pkg::COLUMN_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  tte_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  tte_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata    // [7:0] out_byte, [16:8] repeat_count
);
  import tte_pkg::*;

  localparam int SLOT_COUNT = (MAX_STOPS < STOP_SLOTS) ? MAX_STOPS : STOP_SLOTS;
  localparam int SUM_BITS   = COLUMN_BITS + 1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

  logic [COLUMN_BITS-1:0] column;
  logic [COLUMN_BITS-1:0] column_next;
  logic [7:0]             phase;
  logic [7:0]             phase_next;
  logic [7:0]             out_byte;
  logic [7:0]             out_byte_next;
  logic [8:0]             repeat_count;
  logic [8:0]             repeat_count_next;

  logic [COLUMN_BITS-1:0] col0;
  logic [7:0]             ph0;
  logic [7:0]             nst;
  logic [STOP_BITS-1:0]   stops [SLOT_COUNT];
  logic [STOP_BITS-1:0]   first_stop;
  logic [STOP_BITS-1:0]   width;
  logic [STOP_BITS-1:0]   target;
  logic                   found;
  logic [7:0]             phase_inc;
  logic [COLUMN_BITS-1:0] col_inc;
  logic [SUM_BITS-1:0]    col_sum;

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    col0 = q_head.new_file ? '0 : column;
    ph0  = q_head.new_file ? '0 : phase;

    nst = (32'(cfg.stop_count) > MAX_STOPS) ? 8'(MAX_STOPS) : 8'(cfg.stop_count);

    first_stop = stop_at(cfg.words, 0);
    width      = (first_stop == '0) ? 9'd1 : first_stop;

    for (int n = 0; n < SLOT_COUNT; n++) begin
      stops[n] = stop_at(cfg.words, n);
    end

    // first stop in index order past the column
    found  = 1'b0;
    target = '0;
    for (int n = 0; n < SLOT_COUNT; n++) begin
      if (!found && (8'(n) < nst) && (COLUMN_BITS'(stops[n]) > col0)) begin
        found  = 1'b1;
        target = stops[n];
      end
    end

    phase_inc = (({1'b0, ph0} + 9'd1) >= width) ? '0 : ph0 + 8'd1;
    col_inc   = (col0 == COL_MAX) ? col0 : col0 + 1'b1;

    out_byte_next     = q_head.text_byte;
    repeat_count_next = 9'd1;
    column_next       = col_inc;
    phase_next        = phase_inc;

    case (q_head.kind)
      KIND_TAB: begin
        out_byte_next = SPACE_CHAR;
        phase_next    = '0;
        if (nst == 8'd0) begin
          repeat_count_next = 9'(DEFAULT_WIDTH - {1'b0, col0[2:0]});
        end else if (nst == 8'd1) begin
          repeat_count_next = ({1'b0, ph0} < width) ? width - {1'b0, ph0} : 9'd1;
        end else if (found) begin
          // target lies above the column, so the column fits in nine bits here
          repeat_count_next = target - col0[STOP_BITS-1:0];
        end else begin
          repeat_count_next = 9'd1;
          phase_next        = phase_inc;
        end
        col_sum     = {1'b0, col0} + SUM_BITS'(repeat_count_next);
        column_next = col_sum[COLUMN_BITS] ? COL_MAX : col_sum[COLUMN_BITS-1:0];
      end
      KIND_BS: begin
        col_sum = '0;
        if (col0 != '0) begin
          column_next = col0 - 1'b1;
          phase_next  = (ph0 == '0) ? 8'(width - 9'd1) : ph0 - 8'd1;
        end else begin
          column_next = col0;
          phase_next  = ph0;
        end
      end
      KIND_NL: begin
        col_sum     = '0;
        column_next = '0;
        phase_next  = '0;
      end
      default: begin
        col_sum = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      phase    <= '0;
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      column   <= column_next;
      phase    <= phase_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_byte     <= out_byte_next;
      repeat_count <= repeat_count_next;
    end
  end

  assign m_tdata = {7'd0, repeat_count, out_byte};

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> repeat_count != '0)
    else $error("zero repeat count");

  a_plain_single: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.kind != KIND_TAB) |=> repeat_count == 9'd1)
    else $error("non-tab byte repeated");

  a_newline_home: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.kind == KIND_NL) |=> (column == '0 && phase == '0))
    else $error("newline left column or phase set");

endmodule

// ===== sv/tab_to_space_expander.sv =====
// Top level of the tab expander: config registers and the front/back pair.
//
// Byte stream in on s_* (text_byte in s_tdata, new_file in s_tuser); one beat
// out on m_* per input byte: out_byte and a repeat_count of 1 to 256. A tab
// comes out as a space with the count that reaches the next stop; any other
// byte passes through with a count of 1.
// Config is an APB-style port, 64-bit data, registers at 8-byte steps:
// stop_count, then stop_word_0..3. Write only while the stream is idle.
// Throughput: one byte per cycle while m_tready stays high. The stop search
// and the column update are combinational in the back end, a parallel stop compare.
// When the queue is empty, a beat accepted on s_* reaches m_* through the
// queue write, then the result register.
// When m_tready is low a valid result holds in the result register; the four-entry queue
// keeps taking bytes until full, then s_tready drops.
// Reset clears column, phase, queue, the result valid and all config registers.
module tab_to_space_expander #(
  parameter int MAX_STOPS   = tte_pkg::MAX_STOPS_DEFAULT,
  parameter int COLUMN_BITS = tte_pkg::COLUMN_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tuser,   // [0] new_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [16:8] repeat_count, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import tte_pkg::*;

  cfg_t       cfg;
  logic       q_valid;
  logic       q_pop;
  q_entry_t   q_head;
  logic [2:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[5:3];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      if (reg_index == REG_STOP_COUNT) begin
        cfg.stop_count <= pwdata[4:0];
      end else if (reg_index >= REG_STOP_WORD_0 && reg_index <= REG_STOP_WORD_3) begin
        cfg.words[2'(reg_index - REG_STOP_WORD_0)] <= pwdata[STOP_WORD_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (reg_index == REG_STOP_COUNT) begin
      prdata = {59'd0, cfg.stop_count};
    end else if (reg_index >= REG_STOP_WORD_0 && reg_index <= REG_STOP_WORD_3) begin
      prdata = {1'b0, cfg.words[2'(reg_index - REG_STOP_WORD_0)]};
    end else begin
      prdata = '0;
    end
  end

  tte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  tte_back #(
    .MAX_STOPS   (MAX_STOPS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== tb/sv/tab_to_space_expander_tb.sv =====
// Self-checking testbench for the tab expander: directed cases, then random streams.
`timescale 1ns / 1ps

module tab_to_space_expander_tb;
  import tte_pkg::*;

  localparam int MAX_STOPS   = MAX_STOPS_DEFAULT;
  localparam int COL_MAX     = (1 << COLUMN_BITS_DEFAULT) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_COUNT = 12;
  localparam int PHASE_BEATS = 115;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [8:0] repeat_count;
  } run_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] text_byte
  logic        s_tuser;    // [0] new_file
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;    // [7:0] out_byte, [16:8] repeat_count, rest zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  // predictor copy of registers and state
  logic [4:0]                cfg_stop_count;
  logic [STOP_WORD_BITS-1:0] cfg_words [STOP_WORDS];
  int                        col_pos;
  int                        tab_phase;

  logic [STOP_BITS-1:0] stop_plan [STOP_SLOTS];
  run_t                 expected_runs [$];

  int err_count;
  int cycle_count;
  int bytes_sent;
  int tabs_sent;
  int runs_checked;
  int settings_used;
  int gap_pct;
  int stall_pct;

  tab_to_space_expander i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d runs outstanding", cycle_count,
               expected_runs.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 100)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // ---------------- predictor ----------------

  function automatic int stop_at_slot(input int n);
    int v;
    if (n >= STOP_SLOTS)
      return 0;
    v = cfg_words[n / STOPS_PER_WORD][(n % STOPS_PER_WORD) * STOP_BITS +: STOP_BITS];
    return (v > MAX_STOP_VALUE) ? MAX_STOP_VALUE : v;
  endfunction

  function automatic int tab_width();
    int v;
    v = stop_at_slot(0);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void advance_col(input int k);
    col_pos = (col_pos + k > COL_MAX) ? COL_MAX : col_pos + k;
  endfunction

  function automatic void step_phase();
    int nx;
    nx = tab_phase + 1;
    tab_phase = (nx >= tab_width()) ? 0 : (nx & 8'hFF);
  endfunction

  function automatic run_t expand_byte(input logic [7:0] b, input logic nf);
    run_t r;
    int   nst;
    int   w;
    int   cnt;
    int   v;
    bit   found;
    if (nf) begin
      col_pos = 0;
      tab_phase = 0;
    end
    nst = (cfg_stop_count > MAX_STOPS) ? MAX_STOPS : cfg_stop_count;
    cnt = 1;
    r.out_byte = b;
    if (b == TAB_CHAR) begin
      r.out_byte = SPACE_CHAR;
      if (nst == 0) begin
        cnt = DEFAULT_WIDTH - (col_pos % DEFAULT_WIDTH);
        advance_col(cnt);
        tab_phase = 0;
      end else if (nst == 1) begin
        w = tab_width();
        cnt = (tab_phase < w) ? (w - tab_phase) : 1;
        advance_col(cnt);
        tab_phase = 0;
      end else begin
        found = 0;
        for (int n = 0; n < nst && !found; n++) begin
          v = stop_at_slot(n);
          if (v > col_pos) begin
            found = 1;
            cnt = v - col_pos;
          end
        end
        advance_col(cnt);
        if (found)
          tab_phase = 0;
        else
          step_phase();
      end
    end else if (b == BS_CHAR) begin
      if (col_pos != 0) begin
        col_pos--;
        tab_phase = (tab_phase == 0) ? ((tab_width() - 1) & 8'hFF) : tab_phase - 1;
      end
    end else if (b == NL_CHAR) begin
      col_pos = 0;
      tab_phase = 0;
    end else begin
      advance_col(1);
      step_phase();
    end
    r.repeat_count = cnt[8:0];
    return r;
  endfunction

  // ---------------- stimulus plumbing ----------------

  // called just after a falling edge; returns just after a falling edge
  task automatic send_byte(input logic [7:0] b, input logic nf);
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= nf;
    do @(posedge clk); while (!s_tready);
    expected_runs.push_back(expand_byte(b, nf));
    bytes_sent++;
    if (b == TAB_CHAR)
      tabs_sent++;
    @(negedge clk);
  endtask

  task automatic drain_stream();
    s_tvalid <= 1'b0;
    while (expected_runs.size() != 0) @(negedge clk);
    // two-stage pipe; idles before touching registers
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_STOP_COUNT)
      cfg_stop_count = value[4:0];
    else if (idx <= REG_STOP_WORD_3)
      cfg_words[idx - REG_STOP_WORD_0] = value[STOP_WORD_BITS-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drains the stream, then writes all four stop words and the count
  task automatic load_stops(input logic [4:0] count);
    logic [STOP_WORD_BITS-1:0] word;
    drain_stream();
    for (int k = 0; k < STOP_WORDS; k++) begin
      for (int s = 0; s < STOPS_PER_WORD; s++)
        word[s*STOP_BITS +: STOP_BITS] = stop_plan[k*STOPS_PER_WORD + s];
      write_reg(REG_STOP_WORD_0 + k[2:0], {1'($urandom_range(0, 1)), word});
    end
    write_reg(REG_STOP_COUNT, {59'($urandom), count});
    settings_used++;
  endtask

  task automatic clear_plan();
    foreach (stop_plan[n])
      stop_plan[n] = '0;
  endtask

  // ---------------- result side ----------------

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && stall_pct > 0 && $urandom_range(1, 100) <= stall_pct)
        stall_left = $urandom_range(1, 19);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    run_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected beat out_byte=%0d repeat_count=%0d",
                                  m_tdata[7:0], m_tdata[16:8]));
      end else begin
        want = expected_runs.pop_front();
        runs_checked++;
        if (m_tdata[7:0] !== want.out_byte)
          report_mismatch($sformatf("beat %0d out_byte got %0d want %0d", runs_checked,
                                    m_tdata[7:0], want.out_byte));
        if (m_tdata[16:8] !== want.repeat_count)
          report_mismatch($sformatf("beat %0d repeat_count got %0d want %0d", runs_checked,
                                    m_tdata[16:8], want.repeat_count));
      end
    end
  end

  // ---------------- tests ----------------

  // reset settings: stops every eight columns
  task automatic test_default_mode();
    gap_pct = 20;
    stall_pct = 6;
    send_byte(8'h61, 1'b0);
    send_byte(TAB_CHAR, 1'b0);     // col 1 -> 8
    send_byte(TAB_CHAR, 1'b0);     // full eight
    send_byte(BS_CHAR, 1'b0);
    send_byte(BS_CHAR, 1'b0);
    send_byte(TAB_CHAR, 1'b0);     // col 14 -> 16
    send_byte(NL_CHAR, 1'b0);
    send_byte(BS_CHAR, 1'b0);      // backspace at column zero
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(TAB_CHAR, 1'b1);     // new file clears the column first
  endtask

  task automatic test_uniform_width();
    clear_plan();
    stop_plan[0] = 9'd5;
    load_stops(5'd1);
    send_byte(8'h78, 1'b1);
    send_byte(8'h79, 1'b0);
    send_byte(TAB_CHAR, 1'b0);     // 3 spaces
    send_byte(TAB_CHAR, 1'b0);     // 5 spaces
    send_byte(BS_CHAR, 1'b0);      // phase wraps back to W-1
    send_byte(TAB_CHAR, 1'b0);
    stop_plan[0] = 9'd0;           // width zero acts as one
    load_stops(5'd1);
    send_byte(TAB_CHAR, 1'b0);
    send_byte(8'h41, 1'b0);
    stop_plan[0] = 9'h1FF;         // clamps to 256
    load_stops(5'd1);
    send_byte(TAB_CHAR, 1'b1);
  endtask

  task automatic test_stop_list();
    clear_plan();
    stop_plan[0] = 9'd10;
    stop_plan[1] = 9'd3;           // out of order
    stop_plan[2] = 9'd0;           // never past the column
    stop_plan[3] = 9'd20;
    load_stops(5'd4);
    send_byte(TAB_CHAR, 1'b1);     // -> 10
    send_byte(TAB_CHAR, 1'b0);     // -> 20
    send_byte(TAB_CHAR, 1'b0);     // nothing past: one space
    send_byte(BS_CHAR, 1'b0);
    send_byte(BS_CHAR, 1'b0);
    send_byte(TAB_CHAR, 1'b0);
    send_byte(NL_CHAR, 1'b0);
    for (int n = 0; n < STOP_SLOTS; n++)
      stop_plan[n] = 9'(9 * (n + 1));
    stop_plan[STOP_SLOTS-1] = 9'h1FF;
    load_stops(5'd31);             // count above the slot total
    send_byte(TAB_CHAR, 1'b1);
    send_byte(TAB_CHAR, 1'b0);
  endtask

  // width shrinks under a live phase
  task automatic test_stale_phase();
    clear_plan();
    stop_plan[0] = 9'd10;
    load_stops(5'd1);
    send_byte(8'h30, 1'b1);
    repeat (6) send_byte(8'h31, 1'b0);
    stop_plan[0] = 9'd4;
    load_stops(5'd1);
    send_byte(TAB_CHAR, 1'b0);     // phase 7 >= 4: one space
    stop_plan[0] = 9'd10;
    load_stops(5'd1);
    repeat (7) send_byte(8'h32, 1'b0);
    stop_plan[0] = 9'd3;
    load_stops(5'd1);
    send_byte(8'h33, 1'b0);        // forward step clears a stale phase
    send_byte(TAB_CHAR, 1'b0);
  endtask

  task automatic test_column_saturation();
    gap_pct = 0;
    stall_pct = 0;
    clear_plan();
    stop_plan[0] = 9'd256;
    load_stops(5'd1);
    send_byte(8'h20, 1'b1);
    send_byte(BS_CHAR, 1'b0);
    repeat (258) send_byte(TAB_CHAR, 1'b0);
    send_byte(8'h2E, 1'b0);        // column pinned, phase moves
    send_byte(TAB_CHAR, 1'b0);
    send_byte(BS_CHAR, 1'b0);
    load_stops(5'd0);
    send_byte(TAB_CHAR, 1'b0);
    send_byte(TAB_CHAR, 1'b0);
    stop_plan[0] = 9'd100;
    stop_plan[1] = 9'd200;
    load_stops(5'd2);
    send_byte(TAB_CHAR, 1'b0);
    send_byte(NL_CHAR, 1'b0);
  endtask

  task automatic pick_stops(input int p, output logic [4:0] count);
    int v;
    clear_plan();
    v = 0;
    for (int n = 0; n < STOP_SLOTS; n++) begin
      v += $urandom_range(1, 24);
      stop_plan[n] = (v > MAX_STOP_VALUE) ? MAX_STOP_VALUE : 9'(v);
    end
    case (p)
      0: count = 5'd28;
      1: count = 5'd31;
      2: count = 5'd0;
      3: begin
        count = 5'd1;
        stop_plan[0] = 9'h1FF;
      end
      4: begin
        count = 5'd1;
        stop_plan[0] = 9'd0;
      end
      5: begin
        count = 5'd2;
        stop_plan[0] = 9'd1;
        stop_plan[1] = MAX_STOP_VALUE;
      end
      default: begin
        count = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 2) == 0) begin
          count = 5'd1;
          stop_plan[0] = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 12));
        end
        // occasionally a noisy list: zeros, big values, wrong order
        if ($urandom_range(0, 3) == 0)
          for (int n = 0; n < STOP_SLOTS; n++)
            if ($urandom_range(0, 3) == 0)
              stop_plan[n] = 9'($urandom);
      end
    endcase
  endtask

  task automatic test_random_traffic();
    logic [4:0] count;
    kind_t      kind;
    logic [7:0] b;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      pick_stops(p, count);
      load_stops(count);
      if (p >= PHASE_COUNT - 2) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = $urandom_range(0, 1) ? 15 : 0;
        stall_pct = $urandom_range(0, 1) ? 5 : 0;
      end
      for (int i = 0; i < PHASE_BEATS; i++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: kind = KIND_TAB;
          6, 7, 8:          kind = KIND_BS;
          9:                kind = KIND_NL;
          default:          kind = KIND_TEXT;
        endcase
        case (kind)
          KIND_TAB: b = TAB_CHAR;
          KIND_BS:  b = BS_CHAR;
          KIND_NL:  b = NL_CHAR;
          default:  b = 8'($urandom_range(0, 255));
        endcase
        send_byte(b, $urandom_range(0, 39) == 0);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_stop_count = '0;
    foreach (cfg_words[k])
      cfg_words[k] = '0;
    col_pos = 0;
    tab_phase = 0;
    err_count = 0;
    cycle_count = 0;
    bytes_sent = 0;
    tabs_sent = 0;
    runs_checked = 0;
    settings_used = 0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_mode();
    test_uniform_width();
    test_stop_list();
    test_stale_phase();
    test_column_saturation();
    test_random_traffic();
    drain_stream();

    $display("Sent %0d bytes (%0d tabs) under %0d stop settings; %0d beats checked.",
             bytes_sent, tabs_sent, settings_used, runs_checked);
    $display("Covered every-eight, uniform and list stops, stale phase and column ceiling.");
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tte_pkg.sv
sv/tte_front.sv
sv/tte_back.sv
sv/tab_to_space_expander.sv
tb/sv/tab_to_space_expander_tb.sv
